/* hdl/npvt_pkg.sv */
// ----------------------------------------------------------------------------
// npvt_pkg: types and constants of the nearest point velocity table
// Item layouts, command and status codes, controller states.
// ----------------------------------------------------------------------------
package npvt_pkg;

  localparam int TableDepthDef = 1024;
  localparam int CoordW        = 20;
  localparam int VelW          = 16;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_PRUNE  = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_code_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic [9:0]               entry_index;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [VelW-1:0]   vel_u;
    logic signed [VelW-1:0]   vel_v;
    logic signed [VelW-1:0]   vel_w;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [9:0]               result_index;
    logic [10:0]              table_count;
    logic [10:0]              removed_count;
    logic signed [CoordW-1:0] found_x;
    logic signed [CoordW-1:0] found_y;
    logic signed [CoordW-1:0] found_z;
    logic signed [VelW-1:0]   found_u;
    logic signed [VelW-1:0]   found_v;
    logic signed [VelW-1:0]   found_w;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DONE
  } state_t;

endpackage

/* hdl/nearest_point_velocity_table.sv */
// ----------------------------------------------------------------------------
// nearest_point_velocity_table
// Table of points with position and velocity; append, prune, read, nearest.
// ----------------------------------------------------------------------------
// channel   ports                          direction
// input     start, busy, in_item           in (start while !busy)
// result    out_valid, out_item            out, one cycle, no stall
// config    cfg_we, cfg_wdata              in, threshold register
//
// Clear, append, read and undefined commands go from ST_IDLE through ST_CALC
// to ST_DONE. Prune and query go through ST_CALC to ST_SCAN, which scans the
// memory through one read port, one entry per cycle with a two-stage compute
// pipeline, and then to ST_DONE.
// Reset (synchronous, rst_n low) empties the table; the memory is not cleared.
// busy is high from the accepted item through its result strobe cycle.
module nearest_point_velocity_table
  #(parameter int TABLE_DEPTH = npvt_pkg::TableDepthDef)
  (input  logic                clk,
   input  logic                rst_n,
   input  logic                start,
   output logic                busy,
   input  npvt_pkg::in_item_t  in_item,
   output logic                out_valid,
   output npvt_pkg::out_item_t out_item,
   input  logic                cfg_we,
   input  logic [31:0]         cfg_wdata);

  import npvt_pkg::*;

  localparam int COORD_BITS = CoordW;
  localparam int VEL_BITS   = VelW;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 3*COORD_BITS + 3*VEL_BITS;
  localparam int DW = 2*COORD_BITS + 4;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  state_t        state_r, state_nxt;
  in_item_t      cmd_r;
  logic          drop_r;
  logic [31:0]   thr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_cnt_r, kept_r, removed_r;
  logic          v1_r, v2_r;
  logic [AW-1:0] i1_r, i2_r;
  logic [EW-1:0] e2_r;
  logic [DW-1:0] sq0_r, sq1_r, sq2_r;
  logic          have_r;
  logic [DW-1:0] best_r;
  logic [AW-1:0] besti_r;
  logic [EW-1:0] beste_r;
  out_item_t     res_r;
  logic          done_r;

  logic signed [COORD_BITS-1:0] ex, ey, ez, qx, qy, qz;
  logic signed [VEL_BITS-1:0]   eu, ev, ew;
  logic signed [COORD_BITS:0]   dx, dy, dz;
  logic [DW-1:0]                tot;
  logic                         is_scan;

  assign qx = cmd_r.pos_x[COORD_BITS-1:0];
  assign qy = cmd_r.pos_y[COORD_BITS-1:0];
  assign qz = cmd_r.pos_z[COORD_BITS-1:0];
  assign {ex, ey, ez, eu, ev, ew} = rd_data_r;
  assign dx = {ex[COORD_BITS-1], ex} - {qx[COORD_BITS-1], qx};
  assign dy = {ey[COORD_BITS-1], ey} - {qy[COORD_BITS-1], qy};
  assign tot = sq0_r + sq1_r + sq2_r;
  assign is_scan = (cmd_r.cmd == CMD_PRUNE) || (cmd_r.cmd == CMD_QUERY);

  always_comb begin
    dz = {ez[COORD_BITS-1], ez} - {qz[COORD_BITS-1], qz};
  end

  // Memory: one read port for the scan and for reads, one write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_addr = (state_r == ST_IDLE) ? in_item.entry_index[AW-1:0] : rd_cnt_r[AW-1:0];

  // Append writes at entry_count; prune compacts kept entries in place.
  always_comb begin
    we      = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = {in_item.pos_x[COORD_BITS-1:0], in_item.pos_y[COORD_BITS-1:0],
               in_item.pos_z[COORD_BITS-1:0], in_item.vel_u[VEL_BITS-1:0],
               in_item.vel_v[VEL_BITS-1:0], in_item.vel_w[VEL_BITS-1:0]};
    if (state_r == ST_IDLE && start && in_item.cmd == CMD_APPEND
        && count_r < CW'(TABLE_DEPTH)) begin
      we = 1'b1;
    end else if (state_r == ST_SCAN && cmd_r.cmd == CMD_PRUNE && v2_r
                 && tot > DW'(thr_r)) begin
      we      = 1'b1;
      wr_addr = kept_r[AW-1:0];
      wr_data = e2_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CALC;
      ST_CALC: state_nxt = is_scan ? ST_SCAN : ST_DONE;
      ST_SCAN: if (rd_cnt_r >= count_r && !v1_r && !v2_r && !done_r) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    out_item  = res_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (state_r == ST_IDLE && start) begin
      if (in_item.cmd == CMD_CLEAR) count_nxt = '0;
      else if (in_item.cmd == CMD_APPEND && count_r < CW'(TABLE_DEPTH))
        count_nxt = count_r + CW'(1);
    end else if (state_r == ST_SCAN && state_nxt == ST_DONE && cmd_r.cmd == CMD_PRUNE) begin
      count_nxt = kept_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      thr_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
      // Pipeline: read issued, data registered (v1), squares registered (v2).
      v1_r   <= (state_r == ST_SCAN) && (rd_cnt_r < count_r);
      v2_r   <= v1_r;
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r     <= in_item;
        // An append that finds the table full is dropped.
        drop_r    <= (count_r >= CW'(TABLE_DEPTH));
        rd_cnt_r  <= '0;
        kept_r    <= '0;
        removed_r <= '0;
        have_r    <= 1'b0;
      end
      ST_SCAN: begin
        if (rd_cnt_r < count_r) rd_cnt_r <= rd_cnt_r + CW'(1);
        i1_r <= rd_cnt_r[AW-1:0];
        i2_r <= i1_r;
        e2_r <= rd_data_r;
        if (cmd_r.cmd == CMD_PRUNE) begin
          sq0_r <= DW'(unsigned'(32'(eu * eu)));
          sq1_r <= DW'(unsigned'(32'(ev * ev)));
          sq2_r <= DW'(unsigned'(32'(ew * ew)));
        end else begin
          sq0_r <= DW'(unsigned'((2*COORD_BITS+2)'(dx * dx)));
          sq1_r <= DW'(unsigned'((2*COORD_BITS+2)'(dy * dy)));
          sq2_r <= DW'(unsigned'((2*COORD_BITS+2)'(dz * dz)));
        end
        if (v2_r) begin
          if (cmd_r.cmd == CMD_PRUNE) begin
            if (tot > DW'(thr_r)) kept_r <= kept_r + CW'(1);
            else removed_r <= removed_r + CW'(1);
          end else if (!have_r || tot < best_r) begin
            have_r  <= 1'b1;
            best_r  <= tot;
            besti_r <= i2_r;
            beste_r <= e2_r;
          end
        end
      end
      default: ;
    endcase
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (state_nxt == ST_DONE && state_r != ST_DONE) begin
      res_r <= '0;
      res_r.table_count <= 11'(count_nxt);
      case (cmd_r.cmd)
        CMD_APPEND: if (drop_r) res_r.status <= STATUS_FULL;
        CMD_PRUNE: res_r.removed_count <= 11'(removed_r);
        CMD_QUERY: begin
          if (have_r) begin
            res_r.result_index <= 10'(besti_r);
            res_r.found_x <= CoordW'($signed(beste_r[EW-1 -: COORD_BITS]));
            res_r.found_y <= CoordW'($signed(beste_r[EW-1-COORD_BITS -: COORD_BITS]));
            res_r.found_z <= CoordW'($signed(beste_r[3*VEL_BITS +: COORD_BITS]));
            res_r.found_u <= VelW'($signed(beste_r[2*VEL_BITS +: VEL_BITS]));
            res_r.found_v <= VelW'($signed(beste_r[VEL_BITS +: VEL_BITS]));
            res_r.found_w <= VelW'($signed(beste_r[0 +: VEL_BITS]));
          end else begin
            res_r.status <= STATUS_EMPTY;
          end
        end
        CMD_READ: begin
          if (CW'(cmd_r.entry_index) < count_r
              && {1'b0, cmd_r.entry_index} < 11'(TABLE_DEPTH)) begin
            res_r.result_index <= cmd_r.entry_index;
            res_r.found_x <= CoordW'(ex);
            res_r.found_y <= CoordW'(ey);
            res_r.found_z <= CoordW'(ez);
            res_r.found_u <= VelW'(eu);
            res_r.found_v <= VelW'(ev);
            res_r.found_w <= VelW'(ew);
          end else begin
            res_r.status <= STATUS_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
